@@ design/hufd_pkg.sv @@
// shared types, constants and helpers for the huffman tree walk decoder
`default_nettype none
package hufd_pkg;

	localparam int unsigned NODE_IDX_W   = 9;
	localparam int unsigned SYM_W        = 8;
	localparam int unsigned COUNT_W      = 40;
	localparam int unsigned SCOUNT_W     = 9;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 40;
	localparam int unsigned IN_DATA_W    = 48;
	localparam int unsigned MAX_SYMBOLS  = 256;
	localparam int unsigned TABLE_DEPTH  = 512;
	localparam int unsigned QUEUE_DEPTH  = 2;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH = 2'd1;

	localparam logic [SCOUNT_W-1:0] SYMBOL_COUNT_RESET = 9'd2;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_DATA = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		logic [NODE_IDX_W-1:0] left;
		logic [NODE_IDX_W-1:0] right;
		logic                  leaf;
		logic [SYM_W-1:0]      sym;
	} node_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [NODE_IDX_W-1:0] index;
		node_t                 node;
		logic [7:0]            data_byte;
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ROOT_RD,
		B_ROOT_CAP,
		B_WALK,
		B_FLUSH
	} back_state_t;

	// root = 2*n-2 with n clamped to [2, MAX_SYMBOLS]
	function automatic logic [NODE_IDX_W-1:0] root_of(input logic [SCOUNT_W-1:0] sc);
		logic [SCOUNT_W:0] n;
		logic [SCOUNT_W:0] r;
		n = {1'b0, sc};
		if (n < (SCOUNT_W+1)'(2))
			n = (SCOUNT_W+1)'(2);
		if (n > (SCOUNT_W+1)'(MAX_SYMBOLS))
			n = (SCOUNT_W+1)'(MAX_SYMBOLS);
		r = (n << 1) - (SCOUNT_W+1)'(2);
		return r[NODE_IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ design/hufd_front.sv @@
// input side: accepts stream words, classifies them and queues commands
`default_nettype none
module hufd_front import hufd_pkg::*; #(
	parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// node_index, node_left, node_right, node_is_leaf, node_symbol, data_byte, zero pad
	input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
	// func
	input  wire logic [0:0]           s_axis_tuser,
	output logic                      cmd_valid,
	input  wire logic                 cmd_ready,
	output cmd_t                      cmd
);

	localparam int unsigned PW = $clog2(QDEPTH);
	localparam int unsigned CW = $clog2(QDEPTH + 1);

	cmd_t          queue_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;
	cmd_t          in_cmd;
	logic          push;
	logic          pop;

	always_comb begin
		in_cmd.kind       = s_axis_tuser[0] ? CMD_DATA : CMD_LOAD;
		in_cmd.index      = s_axis_tdata[8:0];
		in_cmd.node.left  = s_axis_tdata[17:9];
		in_cmd.node.right = s_axis_tdata[26:18];
		in_cmd.node.leaf  = s_axis_tdata[27];
		in_cmd.node.sym   = s_axis_tdata[35:28];
		in_cmd.data_byte  = s_axis_tdata[43:36];
	end

	assign s_axis_tready = (fill_q != CW'(QDEPTH));
	assign cmd_valid     = (fill_q != '0);
	assign cmd           = queue_q[rd_ptr_q];
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/hufd_back.sv @@
// execution side: node table, tree walk, symbol hold-back and output register
`default_nettype none
module hufd_back import hufd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  cmd_valid,
	output logic                       cmd_ready,
	input  wire cmd_t                  cmd,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [SYM_W-1:0]           m_axis_tdata,
	output logic                       m_axis_tlast,
	output logic [0:0]                 m_axis_tuser
);

	node_t                 table_mem [TABLE_DEPTH];

	back_state_t           state_q, state_d;
	logic [SCOUNT_W-1:0]   sym_count_q;
	logic [COUNT_W-1:0]    total_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  done_q;
	node_t                 root_q;
	node_t                 cur_q;
	logic [NODE_IDX_W-1:0] cur_idx_q;
	node_t                 rd_q;
	logic [NODE_IDX_W-1:0] rd_idx_q;
	logic                  rd_v_q;
	logic [7:0]            byte_q;
	logic [3:0]            bits_left_q;
	logic                  pend_v_q;
	logic [SYM_W-1:0]      pend_sym_q;
	logic                  pend_done_q;
	logic                  out_v_q;
	logic [SYM_W-1:0]      out_sym_q;
	logic                  out_last_q;
	logic                  out_done_q;

	logic                  cfg_hit;
	logic [NODE_IDX_W-1:0] root_idx;
	logic                  out_free;
	logic                  rd_leaf;
	node_t                 cur_sel;
	logic [NODE_IDX_W-1:0] cur_sel_idx;
	logic [COUNT_W-1:0]    count_inc;
	logic                  hit_end;
	logic                  stall;

	logic                  mem_we;
	logic                  mem_re;
	logic [NODE_IDX_W-1:0] mem_raddr;
	logic                  load_take;
	logic                  byte_load;
	logic                  step;
	logic                  leaf_take;
	logic                  cur_save;
	logic                  root_cap;
	logic                  walk_hold;
	logic                  push_v;
	logic                  push_last;
	logic                  pend_clr;

	assign cfg_hit     = cfg_we && (cfg_index == REG_SYMBOL_COUNT ||
		cfg_index == REG_TOTAL_LENGTH);
	assign root_idx    = root_of(sym_count_q);
	assign out_free    = !out_v_q || m_axis_tready;
	assign rd_leaf     = rd_v_q && rd_q.leaf;
	// node the walk stands on: the one just fetched, the root after a leaf, else the saved node
	assign cur_sel     = rd_v_q ? (rd_q.leaf ? root_q : rd_q) : cur_q;
	assign cur_sel_idx = rd_v_q ? (rd_q.leaf ? root_idx : rd_idx_q) : cur_idx_q;
	assign count_inc   = count_q + 1'b1;
	assign hit_end     = (count_inc == total_q);
	// a new leaf needs the held symbol to move out first
	assign stall       = rd_leaf && pend_v_q && !out_free;

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = root_idx;
		load_take = 1'b0;
		byte_load = 1'b0;
		step      = 1'b0;
		leaf_take = 1'b0;
		cur_save  = 1'b0;
		root_cap  = 1'b0;
		walk_hold = 1'b0;
		push_v    = 1'b0;
		push_last = 1'b0;
		pend_clr  = 1'b0;
		case (state_q)
			B_IDLE: begin
				cmd_ready = !cfg_hit;
				if (cmd_valid && !cfg_hit) begin
					if (cmd.kind == CMD_LOAD) begin
						mem_we    = 1'b1;
						load_take = 1'b1;
					end else if (!done_q) begin
						byte_load = 1'b1;
						state_d   = B_WALK;
					end
				end
			end
			B_ROOT_RD: begin
				mem_re  = 1'b1;
				state_d = B_ROOT_CAP;
			end
			B_ROOT_CAP: begin
				root_cap = 1'b1;
				state_d  = B_IDLE;
			end
			B_WALK: begin
				if (stall) begin
					walk_hold = 1'b1;
				end else begin
					if (rd_leaf) begin
						leaf_take = 1'b1;
						push_v    = pend_v_q;
					end
					if (!(rd_leaf && hit_end) && bits_left_q != '0) begin
						step      = 1'b1;
						mem_re    = 1'b1;
						mem_raddr = byte_q[7] ? cur_sel.right : cur_sel.left;
					end else begin
						cur_save = 1'b1;
						state_d  = B_FLUSH;
					end
				end
			end
			B_FLUSH: begin
				if (!pend_v_q) begin
					state_d = B_IDLE;
				end else if (out_free) begin
					push_v    = 1'b1;
					push_last = 1'b1;
					pend_clr  = 1'b1;
					state_d   = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else if (cfg_hit) begin
			state_q <= B_ROOT_RD;
		end else begin
			state_q <= state_d;
		end
	end

	// node table, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[cmd.index] <= cmd.node;
		end
		if (mem_re) begin
			rd_q     <= table_mem[mem_raddr];
			rd_idx_q <= mem_raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_count_q <= SYMBOL_COUNT_RESET;
			total_q     <= '0;
			count_q     <= '0;
			done_q      <= 1'b1;
			cur_idx_q   <= root_of(SYMBOL_COUNT_RESET);
			rd_v_q      <= 1'b0;
			bits_left_q <= '0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (cfg_hit) begin
				count_q <= '0;
				rd_v_q  <= 1'b0;
				if (cfg_index == REG_SYMBOL_COUNT) begin
					sym_count_q <= cfg_data[SCOUNT_W-1:0];
					done_q      <= (total_q == '0);
				end else begin
					total_q <= cfg_data[COUNT_W-1:0];
					done_q  <= (cfg_data[COUNT_W-1:0] == '0);
				end
			end else begin
				if (leaf_take) begin
					count_q <= count_inc;
					done_q  <= hit_end;
				end
				if (!walk_hold) begin
					rd_v_q <= step;
				end
			end
			if (root_cap) begin
				cur_idx_q <= root_idx;
			end else if (cur_save) begin
				cur_idx_q <= cur_sel_idx;
			end
			if (byte_load) begin
				bits_left_q <= BITS_PER_BYTE;
			end else if (step) begin
				bits_left_q <= bits_left_q - 1'b1;
			end
			if (leaf_take) begin
				pend_v_q <= 1'b1;
			end else if (pend_clr) begin
				pend_v_q <= 1'b0;
			end
			if (push_v) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (root_cap) begin
			root_q <= rd_q;
			cur_q  <= rd_q;
		end else if (cur_save) begin
			cur_q <= cur_sel;
		end else if (load_take) begin
			// keep the cached root and current node in step with table writes
			if (cmd.index == cur_idx_q) begin
				cur_q <= cmd.node;
			end
			if (cmd.index == root_idx) begin
				root_q <= cmd.node;
			end
		end
		if (byte_load) begin
			byte_q <= cmd.data_byte;
		end else if (step) begin
			byte_q <= {byte_q[6:0], 1'b0};
		end
		if (leaf_take) begin
			pend_sym_q  <= rd_q.sym;
			pend_done_q <= hit_end;
		end
		if (push_v) begin
			out_sym_q  <= pend_sym_q;
			out_last_q <= push_last;
			out_done_q <= pend_done_q;
		end
	end

	assign m_axis_tvalid   = out_v_q;
	assign m_axis_tdata    = out_sym_q;
	assign m_axis_tlast    = out_last_q;
	assign m_axis_tuser[0] = out_done_q;

endmodule
`default_nettype wire

@@ design/huffman_tree_walk_decoder.sv @@
// top level of the huffman tree walk decoder
//
// channel  | dir | handshake              | payload
// s_axis   | in  | s_axis_tvalid/tready   | tdata node fields + data_byte, tuser func
// m_axis   | out | m_axis_tvalid/tready   | tdata symbol, tlast last_of_item, tuser stream_done
// cfg      | in  | cfg_we (no wait)       | cfg_index, cfg_data
//
// a load word is written to the node table from idle; a data byte walks one dependent node table read
// per walked bit, can stall on a leaf, then passes through flush back to idle before the next word is taken
// a symbol is held until the next leaf or the end of its byte so the last one can be flagged;
// a new leaf waits in the walk while a symbol is held and the output register is full and not taken
// input words queue in front while the walk runs; a finished stream drops a byte from idle without walking it
// a register write reads the root node back through root_rd and root_cap; nothing decodes before a write
`default_nettype none
module huffman_tree_walk_decoder import hufd_pkg::*; #(
	parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// node_index, node_left, node_right, node_is_leaf, node_symbol, data_byte, zero pad
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// func
	input  wire logic [0:0]            s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// symbol
	output logic [SYM_W-1:0]           m_axis_tdata,
	output logic                       m_axis_tlast,
	// stream_done
	output logic [0:0]                 m_axis_tuser,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	hufd_front #(
		.QDEPTH(QDEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd)
	);

	hufd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	// a queued command that is not taken stays at the head unchanged
	a_queue_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
		else $error("queue head changed while waiting");

	// the word that completes the stream is always the last one of its byte
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("stream_done without tlast");

	// a register write makes the back end refetch the root before taking commands
	a_cfg_blocks_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_SYMBOL_COUNT || cfg_index == REG_TOTAL_LENGTH)
		|=> !cmd_ready)
		else $error("command taken during root refetch");

endmodule
`default_nettype wire
